// File: rtl/sli_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// sli_pkg - shared types and constants of the sorted leaf
// Result kinds, default slot count and the record that walks the cell row.
// ----------------------------------------------------------------------------
package sli_pkg;

    localparam int LEAF_SLOTS_DEFAULT = 16;
    localparam int KEY_W              = 32;

    typedef enum logic [1:0] {
        KIND_LOOKUP = 2'd0,
        KIND_INSERT = 2'd1,
        KIND_SPLIT  = 2'd2,
        KIND_MOVED  = 2'd3
    } t_kind;

    // Lookup request as it travels from cell to cell.
    typedef struct packed {
        logic                    valid;
        logic                    found;
        logic signed [KEY_W-1:0] key;
        logic signed [KEY_W-1:0] value;
    } t_query;

    // Per-cell control from the sequencer.
    typedef struct packed {
        logic ins;       // insert request this cycle
        logic drain;     // take the right-hand neighbour's pair
        logic occupied;  // cell index below the fill count
        logic at_count;  // cell index equals the fill count
    } t_cell_ctl;

endpackage
`default_nettype wire

// File: rtl/sli_cell.sv
`default_nettype none
// ----------------------------------------------------------------------------
// sli_cell - one slot of the sorted leaf
// Holds a key/value pair, shifts right on insert, left on drain, and checks
// the passing lookup request against its own key.
// ----------------------------------------------------------------------------
module sli_cell (
    input  wire logic                                 i_clk,
    input  wire logic                                 i_rst_n,
    input  wire sli_pkg::t_cell_ctl                   i_ctl,
    input  wire logic signed [sli_pkg::KEY_W-1:0]     i_new_key,
    input  wire logic signed [sli_pkg::KEY_W-1:0]     i_new_value,
    input  wire logic                                 i_left_gt,
    input  wire logic signed [sli_pkg::KEY_W-1:0]     i_left_key,
    input  wire logic signed [sli_pkg::KEY_W-1:0]     i_left_value,
    input  wire logic signed [sli_pkg::KEY_W-1:0]     i_right_key,
    input  wire logic signed [sli_pkg::KEY_W-1:0]     i_right_value,
    input  wire sli_pkg::t_query                      i_query,
    output logic                                      o_gt,
    output logic signed [sli_pkg::KEY_W-1:0]          o_key,
    output logic signed [sli_pkg::KEY_W-1:0]          o_value,
    output sli_pkg::t_query                           o_query
);

    logic signed [sli_pkg::KEY_W-1:0] r_key, n_key;
    logic signed [sli_pkg::KEY_W-1:0] r_value, n_value;
    sli_pkg::t_query                  r_query, n_query;

    assign o_gt = i_ctl.occupied && (r_key > i_new_key);

    always_comb begin
        n_key   = r_key;
        n_value = r_value;
        if (i_ctl.ins) begin
            if (i_left_gt) begin
                n_key   = i_left_key;
                n_value = i_left_value;
            end else if (o_gt || i_ctl.at_count) begin
                n_key   = i_new_key;
                n_value = i_new_value;
            end
        end else if (i_ctl.drain) begin
            n_key   = i_right_key;
            n_value = i_right_value;
        end
    end

    always_comb begin
        n_query = i_query;
        // first match wins: later cells see found already set
        if (i_query.valid && !i_query.found && i_ctl.occupied && i_query.key == r_key) begin
            n_query.found = 1'b1;
            n_query.value = r_value;
        end
    end

    always_ff @(posedge i_clk) begin
        r_key   <= n_key;
        r_value <= n_value;
        if (!i_rst_n) begin
            r_query <= '0;
        end else begin
            r_query <= n_query;
        end
    end

    assign o_key   = r_key;
    assign o_value = r_value;
    assign o_query = r_query;

endmodule
`default_nettype wire

// File: rtl/sorted_leaf_insert_split_core.sv
`default_nettype none
// ----------------------------------------------------------------------------
// sorted_leaf_insert_split_core - one key-sorted tree leaf with split
// A row of LEAF_SLOTS cells keeps the pairs in signed key order.
// ----------------------------------------------------------------------------
// Input channel (i_valid / o_ready) takes one request at a time: a lookup
// (i_operation 0) or an insert (i_operation 1). o_ready is high only while
// the sequencer is idle.
// Output channel (o_valid / i_ready) carries results from one output
// register; o_last marks the final result of a request.
// Insert: all cells shift in the accepting cycle; S_EMIT_INS then loads the
// answer once the output register is free.
// Lookup: the request walks the cell row one cell a cycle; S_LOOK catches it
// as it leaves the last cell and S_EMIT_LOOK then loads the answer.
// Split: when the leaf reaches LEAF_SLOTS entries it keeps slots 0 to MID,
// sends the middle key, then drains the upper LEAF_SLOTS - MID - 1 entries
// through the cell just above the middle, one result a cycle unless stalled.
// A stalled receiver holds the output register and freezes the sequence.
// Reset empties the leaf and drops any pending result; no clearing pass.
// ----------------------------------------------------------------------------
module sorted_leaf_insert_split_core #(
    parameter int LEAF_SLOTS = sli_pkg::LEAF_SLOTS_DEFAULT
) (
    input  wire logic                              i_clk,
    input  wire logic                              i_rst_n,
    input  wire logic                              i_valid,
    output logic                                   o_ready,
    input  wire logic                              i_operation,
    input  wire logic signed [sli_pkg::KEY_W-1:0]  i_key,
    input  wire logic signed [sli_pkg::KEY_W-1:0]  i_value,
    output logic                                   o_valid,
    input  wire logic                              i_ready,
    output logic [1:0]                             o_kind,
    output logic                                   o_found,
    output logic signed [sli_pkg::KEY_W-1:0]       o_key_out,
    output logic signed [sli_pkg::KEY_W-1:0]       o_value_out,
    output logic                                   o_nearly_full,
    output logic                                   o_last
);

    localparam int CW    = $clog2(LEAF_SLOTS + 1);
    localparam int MID   = LEAF_SLOTS / 2;
    localparam int MOVES = LEAF_SLOTS - MID - 1;
    localparam int LW    = $clog2(MOVES + 1);
    localparam logic [CW-1:0] CNT_FULL  = CW'(LEAF_SLOTS - 1);
    localparam logic [CW-1:0] CNT_SPLIT = CW'(MID + 1);
    localparam logic          SPLIT_LAST = (MID + 1 >= LEAF_SLOTS);

    typedef enum logic [2:0] {
        S_IDLE, S_LOOK, S_EMIT_LOOK, S_EMIT_INS, S_SPLIT_KEY, S_MOVED
    } t_state;

    t_state                           r_state;
    logic [CW-1:0]                    r_count;
    logic [LW-1:0]                    r_left;
    logic                             r_res_found;
    logic signed [sli_pkg::KEY_W-1:0] r_res_value;
    logic                             r_o_valid, r_o_found, r_o_nf, r_o_last;
    sli_pkg::t_kind                   r_o_kind;
    logic signed [sli_pkg::KEY_W-1:0] r_o_key, r_o_value;

    logic                             w_accept, w_slot, w_ins, w_drain, w_nf, w_load;
    logic signed [sli_pkg::KEY_W-1:0] w_key [LEAF_SLOTS];
    logic signed [sli_pkg::KEY_W-1:0] w_val [LEAF_SLOTS];
    logic                             w_gt  [LEAF_SLOTS];
    sli_pkg::t_query                  w_q   [LEAF_SLOTS+1];

    assign o_ready  = (r_state == S_IDLE);
    assign w_accept = i_valid && o_ready;
    assign w_slot   = !r_o_valid || i_ready;
    assign w_ins    = w_accept && i_operation;
    assign w_drain  = (r_state == S_MOVED) && w_slot;
    assign w_nf     = ({1'b0, r_count} + (CW+1)'(1)) >= (CW+1)'(LEAF_SLOTS);
    // output register takes a new result this cycle
    assign w_load   = w_slot && (r_state == S_EMIT_LOOK || r_state == S_EMIT_INS ||
                                 r_state == S_SPLIT_KEY || r_state == S_MOVED);

    always_comb begin
        w_q[0].valid = w_accept && !i_operation;
        w_q[0].found = 1'b0;
        w_q[0].key   = i_key;
        w_q[0].value = '1;
    end

    for (genvar g = 0; g < LEAF_SLOTS; g++) begin : g_cell
        sli_pkg::t_cell_ctl               w_ctl;
        logic                             w_lgt;
        logic signed [sli_pkg::KEY_W-1:0] w_lkey, w_lval, w_rkey, w_rval;

        assign w_ctl.ins      = w_ins;
        assign w_ctl.drain    = w_drain && (g > MID) && (g < LEAF_SLOTS - 1);
        assign w_ctl.occupied = (r_count > CW'(g));
        assign w_ctl.at_count = (r_count == CW'(g));

        if (g == 0) begin : g_first
            assign w_lgt  = 1'b0;
            assign w_lkey = w_key[g];
            assign w_lval = w_val[g];
        end else begin : g_inner
            assign w_lgt  = w_gt[g-1];
            assign w_lkey = w_key[g-1];
            assign w_lval = w_val[g-1];
        end

        if (g == LEAF_SLOTS - 1) begin : g_end
            assign w_rkey = w_key[g];
            assign w_rval = w_val[g];
        end else begin : g_mid
            assign w_rkey = w_key[g+1];
            assign w_rval = w_val[g+1];
        end

        sli_cell u_cell (
            .i_clk        (i_clk),
            .i_rst_n      (i_rst_n),
            .i_ctl        (w_ctl),
            .i_new_key    (i_key),
            .i_new_value  (i_value),
            .i_left_gt    (w_lgt),
            .i_left_key   (w_lkey),
            .i_left_value (w_lval),
            .i_right_key  (w_rkey),
            .i_right_value(w_rval),
            .i_query      (w_q[g]),
            .o_gt         (w_gt[g]),
            .o_key        (w_key[g]),
            .o_value      (w_val[g]),
            .o_query      (w_q[g+1])
        );
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_IDLE;
            r_count   <= '0;
            r_o_valid <= 1'b0;
        end else begin
            if (r_o_valid && i_ready && !w_load) begin
                r_o_valid <= 1'b0;
            end
            unique case (r_state)
                S_IDLE: begin
                    if (i_valid) begin
                        if (!i_operation) begin
                            r_state <= S_LOOK;
                        end else if (r_count == CNT_FULL) begin
                            r_count <= CNT_SPLIT;
                            r_state <= S_SPLIT_KEY;
                        end else begin
                            r_count <= r_count + CW'(1);
                            r_state <= S_EMIT_INS;
                        end
                    end
                end
                S_LOOK: begin
                    // catch the request as it leaves the last cell
                    if (w_q[LEAF_SLOTS].valid) begin
                        r_res_found <= w_q[LEAF_SLOTS].found;
                        r_res_value <= w_q[LEAF_SLOTS].value;
                        r_state     <= S_EMIT_LOOK;
                    end
                end
                S_EMIT_LOOK: begin
                    if (w_slot) begin
                        r_o_valid <= 1'b1;
                        r_o_kind  <= sli_pkg::KIND_LOOKUP;
                        r_o_found <= r_res_found;
                        r_o_key   <= '0;
                        r_o_value <= r_res_value;
                        r_o_nf    <= w_nf;
                        r_o_last  <= 1'b1;
                        r_state   <= S_IDLE;
                    end
                end
                S_EMIT_INS: begin
                    if (w_slot) begin
                        r_o_valid <= 1'b1;
                        r_o_kind  <= sli_pkg::KIND_INSERT;
                        r_o_found <= 1'b0;
                        r_o_key   <= '0;
                        r_o_value <= '0;
                        r_o_nf    <= w_nf;
                        r_o_last  <= 1'b1;
                        r_state   <= S_IDLE;
                    end
                end
                S_SPLIT_KEY: begin
                    if (w_slot) begin
                        r_o_valid <= 1'b1;
                        r_o_kind  <= sli_pkg::KIND_SPLIT;
                        r_o_found <= 1'b0;
                        r_o_key   <= w_key[MID];
                        r_o_value <= '0;
                        r_o_nf    <= w_nf;
                        r_o_last  <= SPLIT_LAST;
                        r_left    <= LW'(MOVES);
                        r_state   <= S_MOVED;
                    end
                end
                S_MOVED: begin
                    // next moved pair always sits just above the middle
                    if (w_slot) begin
                        r_o_valid <= 1'b1;
                        r_o_kind  <= sli_pkg::KIND_MOVED;
                        r_o_found <= 1'b0;
                        r_o_key   <= w_key[MID+1];
                        r_o_value <= w_val[MID+1];
                        r_o_nf    <= w_nf;
                        r_o_last  <= (r_left == LW'(1));
                        r_left    <= r_left - LW'(1);
                        if (r_left == LW'(1)) begin
                            r_state <= S_IDLE;
                        end
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    assign o_valid       = r_o_valid;
    assign o_kind        = r_o_kind;
    assign o_found       = r_o_found;
    assign o_key_out     = r_o_key;
    assign o_value_out   = r_o_value;
    assign o_nearly_full = r_o_nf;
    assign o_last        = r_o_last;

endmodule
`default_nettype wire

// File: rtl/sli_checker.sv
`default_nettype none
// ----------------------------------------------------------------------------
// sli_checker - port-level checks of the sorted leaf
// Watches the top level's channels and flags result sequences that break
// the request/result contract.
// ----------------------------------------------------------------------------
module sli_checker (
    input wire logic                              i_clk,
    input wire logic                              i_rst_n,
    input wire logic                              i_valid,
    input wire logic                              o_ready,
    input wire logic                              o_valid,
    input wire logic                              i_ready,
    input wire logic [1:0]                        o_kind,
    input wire logic                              o_found,
    input wire logic signed [sli_pkg::KEY_W-1:0]  o_key_out,
    input wire logic signed [sli_pkg::KEY_W-1:0]  o_value_out,
    input wire logic                              o_last
);

    // stalled result holds
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !i_ready |=> o_valid && $stable(o_kind) && $stable(o_key_out)
            && $stable(o_value_out) && $stable(o_last))
        else $error("stalled result changed");

    // one request at a time
    a_one: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_valid && o_ready |=> !o_ready)
        else $error("request taken while busy");

    a_look: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_kind == sli_pkg::KIND_LOOKUP |-> o_last)
        else $error("lookup answer not last");

    a_ins: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_kind == sli_pkg::KIND_INSERT |-> o_last && !o_found)
        else $error("bad insert result");

    // a split always has moved entries after the split key
    a_split: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_kind == sli_pkg::KIND_SPLIT |-> !o_last && !o_found)
        else $error("bad split key result");

endmodule

bind sorted_leaf_insert_split_core sli_checker u_sli_checker (.*);
`default_nettype wire

// File: verif/sorted_leaf_insert_split_core_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sorted_leaf_insert_split_core_tb - self-checking bench for the sorted leaf
// Drives lookups and inserts through the request channel and mirrors the leaf
// in a local table. Every result is compared with the one that table predicts,
// including split keys and moved entries. Random stalls appear on both sides.
// ----------------------------------------------------------------------------
module sorted_leaf_insert_split_core_tb;

    localparam int  LEAF_SLOTS   = sli_pkg::LEAF_SLOTS_DEFAULT;
    localparam int  KEY_W        = sli_pkg::KEY_W;
    localparam int  CLK_PERIOD   = 4;
    localparam int  RESET_CYCLES = 8;
    localparam int  RANDOM_ITEMS = 480;
    localparam int  CALM_TAIL    = 60;
    localparam int  LONG_HOLD    = 250;
    localparam int  HOLD_AFTER   = 300;
    localparam int  DRAIN_AT     = 240;
    localparam int  SETTLE_CYCLES = 2 * LEAF_SLOTS + 8;
    localparam int  IDLE_LIMIT   = 2500;
    localparam int  MAX_REPORTS  = 100;
    localparam int  HISTORY_MAX  = 64;

    localparam bit  OP_LOOKUP = 1'b0;
    localparam bit  OP_INSERT = 1'b1;

    localparam logic signed [KEY_W-1:0] KEY_MIN = 32'sh8000_0000;
    localparam logic signed [KEY_W-1:0] KEY_MAX = 32'sh7fff_ffff;

    typedef struct {
        bit                      op;
        logic signed [KEY_W-1:0] key;
        logic signed [KEY_W-1:0] value;
        bit                      wait_drained;
    } t_leaf_request;

    typedef struct {
        sli_pkg::t_kind          kind;
        bit                      found;
        logic signed [KEY_W-1:0] key;
        logic signed [KEY_W-1:0] value;
        bit                      nearly_full;
        bit                      last;
    } t_leaf_result;

    logic                    i_clk = 1'b0;
    logic                    i_rst_n = 1'b0;
    logic                    i_valid = 1'b0;
    logic                    o_ready;
    logic                    i_operation = 1'b0;
    logic signed [KEY_W-1:0] i_key = '0;
    logic signed [KEY_W-1:0] i_value = '0;
    logic                    o_valid;
    logic                    i_ready = 1'b0;
    logic [1:0]              o_kind;
    logic                    o_found;
    logic signed [KEY_W-1:0] o_key_out;
    logic signed [KEY_W-1:0] o_value_out;
    logic                    o_nearly_full;
    logic                    o_last;

    // Mirror of the leaf contents.
    logic signed [KEY_W-1:0] leaf_key   [LEAF_SLOTS];
    logic signed [KEY_W-1:0] leaf_value [LEAF_SLOTS];
    int                      leaf_count = 0;

    t_leaf_request           request_queue[$];
    t_leaf_result            results_due[$];
    logic signed [KEY_W-1:0] key_history[$];

    t_leaf_request           cur_req;
    bit                      offering = 1'b0;
    bit                      calm = 1'b0;
    int                      gap_left = 0;
    int                      stall_left = 0;
    int                      hold_left = 0;
    bit                      hold_done = 1'b0;
    int                      results_seen = 0;
    int                      fail_count = 0;
    int                      idle_cycles = 0;

    sorted_leaf_insert_split_core #(
        .LEAF_SLOTS (LEAF_SLOTS)
    ) i_dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_valid       (i_valid),
        .o_ready       (o_ready),
        .i_operation   (i_operation),
        .i_key         (i_key),
        .i_value       (i_value),
        .o_valid       (o_valid),
        .i_ready       (i_ready),
        .o_kind        (o_kind),
        .o_found       (o_found),
        .o_key_out     (o_key_out),
        .o_value_out   (o_value_out),
        .o_nearly_full (o_nearly_full),
        .o_last        (o_last)
    );

    always #(CLK_PERIOD / 2) i_clk = ~i_clk;

    // Append one predicted result.
    function automatic void add_due(input t_leaf_result res);
        results_due = {results_due, res};
    endfunction

    // Apply one request to the mirror and queue the results it should produce.
    function automatic void compute_leaf_results(input t_leaf_request req);
        int                      pos;
        int                      n;
        int                      mid;
        bit                      hit;
        bit                      nf;
        logic signed [KEY_W-1:0] answer;
        if (req.op == OP_LOOKUP) begin
            hit    = 1'b0;
            answer = -1;
            for (int i = 0; i < leaf_count; i++) begin
                if (!hit && leaf_key[i] == req.key) begin
                    hit    = 1'b1;
                    answer = leaf_value[i];
                end
            end
            nf = (leaf_count + 1 >= LEAF_SLOTS);
            add_due('{sli_pkg::KIND_LOOKUP, hit, '0, answer, nf, 1'b1});
            return;
        end
        // Insert after any equal keys: first slot holding a strictly greater key.
        pos = leaf_count;
        for (int i = leaf_count - 1; i >= 0; i--) begin
            if (leaf_key[i] > req.key) pos = i;
        end
        for (int i = leaf_count; i > pos; i--) begin
            leaf_key[i]   = leaf_key[i-1];
            leaf_value[i] = leaf_value[i-1];
        end
        leaf_key[pos]   = req.key;
        leaf_value[pos] = req.value;
        n = leaf_count + 1;
        if (n < LEAF_SLOTS) begin
            leaf_count = n;
            nf = (leaf_count + 1 >= LEAF_SLOTS);
            add_due('{sli_pkg::KIND_INSERT, 1'b0, '0, '0, nf, 1'b1});
            return;
        end
        mid        = n / 2;
        leaf_count = mid + 1;
        nf         = (leaf_count + 1 >= LEAF_SLOTS);
        add_due('{sli_pkg::KIND_SPLIT, 1'b0, leaf_key[mid], '0, nf, (mid + 1 >= n)});
        for (int i = mid + 1; i < n; i++) begin
            add_due('{sli_pkg::KIND_MOVED, 1'b0, leaf_key[i], leaf_value[i], nf,
                      (i == n - 1)});
        end
    endfunction

    function automatic void add_request(input bit op, input logic signed [KEY_W-1:0] key,
                                        input logic signed [KEY_W-1:0] value,
                                        input bit wait_drained = 1'b0);
        t_leaf_request req;
        req = '{op, key, value, wait_drained};
        request_queue = {request_queue, req};
        if (op == OP_INSERT) begin
            key_history = {key_history, key};
            if (key_history.size() > HISTORY_MAX) void'(key_history.pop_front());
        end
    endfunction

    // Bias keys towards a small pool and earlier inserts so duplicates and hits occur.
    function automatic logic signed [KEY_W-1:0] pick_key();
        int sel;
        sel = $urandom_range(0, 9);
        if (sel < 4) return $signed($urandom_range(0, 8)) - 4;
        if (sel < 7 && key_history.size() > 0)
            return key_history[$urandom_range(0, key_history.size() - 1)];
        if (sel == 9) begin
            case ($urandom_range(0, 3))
                0: return KEY_MIN;
                1: return KEY_MAX;
                2: return -1;
                default: return 0;
            endcase
        end
        return $urandom;
    endfunction

    function automatic void check_field(input string name, input logic [KEY_W-1:0] want,
                                        input logic [KEY_W-1:0] got);
        if (got !== want) begin
            fail_count++;
            if (fail_count <= MAX_REPORTS)
                $error("%s mismatch: expected 0x%h, actual 0x%h", name, want, got);
        end
    endfunction

    // Request driver.
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (offering && o_ready) begin
                compute_leaf_results(cur_req);
                offering = 1'b0;
            end
            calm = (request_queue.size() < CALM_TAIL);
            if (!offering) begin
                if (gap_left > 0) begin
                    gap_left--;
                end else if (request_queue.size() > 0 &&
                             (!request_queue[0].wait_drained || results_due.size() == 0)) begin
                    if (!calm && $urandom_range(0, 4) == 0) begin
                        gap_left = $urandom_range(1, 11) - 1;
                    end else begin
                        cur_req  = request_queue.pop_front();
                        offering = 1'b1;
                        i_operation <= cur_req.op;
                        i_key       <= cur_req.key;
                        i_value     <= cur_req.value;
                    end
                end
            end
            i_valid <= offering;
        end
    end

    // Result monitor and receiver back-pressure.
    always @(posedge i_clk) begin
        t_leaf_result exp;
        bit           ready_next;
        if (i_rst_n) begin
            if (o_valid && i_ready) begin
                results_seen++;
                if (results_due.size() == 0) begin
                    fail_count++;
                    if (fail_count <= MAX_REPORTS)
                        $error("result with none expected: kind %0d key 0x%h value 0x%h",
                               o_kind, o_key_out, o_value_out);
                end else begin
                    exp = results_due.pop_front();
                    check_field("kind", exp.kind, o_kind);
                    check_field("found", exp.found, o_found);
                    check_field("key_out", exp.key, o_key_out);
                    check_field("value_out", exp.value, o_value_out);
                    check_field("nearly_full", exp.nearly_full, o_nearly_full);
                    check_field("last", exp.last, o_last);
                end
            end
            // Hold off once for a long stretch so the leaf backs up into the request side.
            if (hold_left > 0) begin
                hold_left--;
                ready_next = 1'b0;
            end else if (!hold_done && results_seen >= HOLD_AFTER) begin
                hold_done  = 1'b1;
                hold_left  = LONG_HOLD - 1;
                ready_next = 1'b0;
            end else if (stall_left > 0) begin
                stall_left--;
                ready_next = 1'b0;
            end else if (!calm && $urandom_range(0, 7) == 0) begin
                stall_left = $urandom_range(1, 11) - 1;
                ready_next = 1'b0;
            end else begin
                ready_next = 1'b1;
            end
            i_ready <= ready_next;
        end
    end

    always @(posedge i_clk) begin
        if ((i_valid && o_ready) || (o_valid && i_ready)) begin
            idle_cycles <= 0;
        end else if (idle_cycles + 1 >= IDLE_LIMIT) begin
            $display("simulation failed");
            $finish;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    initial begin
        // Directed: empty leaf, extremes, duplicates, filling up and a split.
        add_request(OP_LOOKUP, 0, 32'sh1234_5678);
        add_request(OP_INSERT, KEY_MAX, KEY_MIN);
        add_request(OP_INSERT, KEY_MIN, KEY_MAX);
        add_request(OP_INSERT, 0, 32'shaaaa_5555);
        add_request(OP_INSERT, 0, 32'sh5555_aaaa);
        add_request(OP_INSERT, 0, -1);
        add_request(OP_LOOKUP, 0, 0);
        add_request(OP_LOOKUP, KEY_MIN, 0);
        add_request(OP_LOOKUP, KEY_MAX, 0);
        add_request(OP_LOOKUP, 5, -1);
        for (int i = 1; i <= 10; i++) add_request(OP_INSERT, -i, i);
        add_request(OP_LOOKUP, -10, 0);
        add_request(OP_INSERT, 0, 7);
        add_request(OP_LOOKUP, KEY_MAX, 0);
        add_request(OP_LOOKUP, -3, 0);
        add_request(OP_LOOKUP, -2, 0);

        for (int i = 0; i < RANDOM_ITEMS; i++) begin
            add_request(($urandom_range(0, 19) < 11) ? OP_INSERT : OP_LOOKUP, pick_key(),
                        $urandom, (i == DRAIN_AT));
        end

        repeat (RESET_CYCLES) @(posedge i_clk);
        i_rst_n <= 1'b1;

        while (request_queue.size() != 0 || offering || results_due.size() != 0)
            @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);

        if (fail_count == 0) begin
            $display("simulation ok");
        end else begin
            $display("simulation failed");
        end
        $finish;
    end

endmodule

// File: files.f
rtl/sli_pkg.sv
rtl/sli_cell.sv
rtl/sorted_leaf_insert_split_core.sv
rtl/sli_checker.sv
verif/sorted_leaf_insert_split_core_tb.sv
